@@ hw/rtl/gap_buffer_text_editor_top_defines.svh @@
// Assertion macros shared by the gap buffer text editor RTL.
`ifndef GAP_BUFFER_TEXT_EDITOR_TOP_DEFINES_SVH
`define GAP_BUFFER_TEXT_EDITOR_TOP_DEFINES_SVH

`ifndef SYNTH

// Check a property at every rising clock edge, masked while reset is applied.
`define GBTE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gbte assertion failed");

// Check a property at every rising clock edge, reset included.
`define GBTE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("gbte assertion failed");

`else

`define GBTE_ASSERT(lbl, clk, rst_n, prop)
`define GBTE_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ hw/rtl/gbte_pkg.sv @@
// Package with sizes, action codes and states of the gap buffer text editor.
`timescale 1ns / 1ps
`default_nettype none

package gbte_pkg;

    localparam int CAPACITY = 4096;
    localparam int WINDOW   = 10;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int LEN_W   = $clog2(CAPACITY + 1);
    localparam int WIN_W   = $clog2(WINDOW + 1);
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 16;
    localparam int AMT_W   = 13;

    typedef enum logic [1:0] {
        ACT_INSERT     = 2'd0,
        ACT_DELETE     = 2'd1,
        ACT_MOVE_LEFT  = 2'd2,
        ACT_MOVE_RIGHT = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_WIN_RD,
        ST_WIN_CAP
    } t_state;

endpackage

`default_nettype wire

@@ hw/rtl/gap_buffer_text_editor_top.sv @@
// Gap buffer text editor: character store, cursor copy engine and window readout.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_action, i_text_char, i_count
//  out     | output    | o_out_valid / i_out_stall  | o_status, o_amount, o_window_char,
//          |           |                            | o_char_valid, o_last
//
// Insert and delete are handled directly from idle. A move of n places runs n reads in the copy
// loop (one read per cycle, each write in the cycle after its read, then a settle step), or
// skips straight on when n is zero; then each window word is read from the store and captured,
// at most WINDOW words, or a single word with no character for an empty window.
// Synchronous active-low reset clears the lengths and control; the store is not cleared.
// Input stalls while a move is in progress or while a result word waits for the sink.
`timescale 1ns / 1ps
`default_nettype none
`include "gap_buffer_text_editor_top_defines.svh"

module gap_buffer_text_editor_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output      logic                          o_in_stall,
    input  wire logic [1:0]                    i_action,
    input  wire logic [gbte_pkg::CHAR_W-1:0]   i_text_char,
    input  wire logic [gbte_pkg::COUNT_W-1:0]  i_count,
    output      logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    output      logic                          o_status,
    output      logic [gbte_pkg::AMT_W-1:0]    o_amount,
    output      logic [gbte_pkg::CHAR_W-1:0]   o_window_char,
    output      logic                          o_char_valid,
    output      logic                          o_last
);

    localparam int ADDR_W = gbte_pkg::ADDR_W;
    localparam int LEN_W  = gbte_pkg::LEN_W;
    localparam int WIN_W  = gbte_pkg::WIN_W;
    localparam int CHAR_W = gbte_pkg::CHAR_W;
    localparam int AMT_W  = gbte_pkg::AMT_W;

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(gbte_pkg::CAPACITY);
    localparam logic [LEN_W-1:0] WIN_LEN = LEN_W'(gbte_pkg::WINDOW);

    // character store
    logic [CHAR_W-1:0] mem [gbte_pkg::CAPACITY];
    logic [CHAR_W-1:0] r_rdata;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CHAR_W-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // control state
    gbte_pkg::t_state  r_state, n_state;
    logic [LEN_W-1:0]  r_before, n_before;
    logic [LEN_W-1:0]  r_after, n_after;
    logic [LEN_W-1:0]  r_rem, n_rem;
    logic              r_dir_right, n_dir_right;
    logic              r_wv, n_wv;
    logic [ADDR_W-1:0] r_waddr, n_waddr;
    logic [ADDR_W-1:0] r_wpos, n_wpos;
    logic [WIN_W-1:0]  r_wleft, n_wleft;
    logic [WIN_W-1:0]  r_wlen, n_wlen;

    // output register
    logic              r_ovalid, n_ovalid;
    logic              r_ostatus, n_ostatus;
    logic [AMT_W-1:0]  r_oamount, n_oamount;
    logic [CHAR_W-1:0] r_ochar, n_ochar;
    logic              r_ocv, n_ocv;
    logic              r_olast, n_olast;

    logic                   out_free;
    logic                   in_acc;
    logic [LEN_W-1:0]       clip_before;
    logic [LEN_W-1:0]       clip_after;
    logic [LEN_W:0]         fill;
    logic                   full;
    logic [LEN_W-1:0]       win_len;
    gbte_pkg::t_action      act;

    assign out_free    = !r_ovalid || !i_out_stall;
    assign o_in_stall  = (r_state != gbte_pkg::ST_IDLE) || !out_free;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign act         = gbte_pkg::t_action'(i_action);
    assign fill        = {1'b0, r_before} + {1'b0, r_after};
    assign full        = fill >= {1'b0, CAP_LEN};
    assign clip_before = (gbte_pkg::COUNT_W'(r_before) < i_count) ? r_before
                                                                  : LEN_W'(i_count);
    assign clip_after  = (gbte_pkg::COUNT_W'(r_after) < i_count) ? r_after
                                                                 : LEN_W'(i_count);
    assign win_len     = (r_before < WIN_LEN) ? r_before : WIN_LEN;

    always_comb begin
        n_state     = r_state;
        n_before    = r_before;
        n_after     = r_after;
        n_rem       = r_rem;
        n_dir_right = r_dir_right;
        n_wv        = 1'b0;
        n_waddr     = r_waddr;
        n_wpos      = r_wpos;
        n_wleft     = r_wleft;
        n_wlen      = r_wlen;
        n_ovalid    = r_ovalid && i_out_stall;
        n_ostatus   = r_ostatus;
        n_oamount   = r_oamount;
        n_ochar     = r_ochar;
        n_ocv       = r_ocv;
        n_olast     = r_olast;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = r_waddr;
        wr_data     = r_rdata;

        unique case (r_state)
            gbte_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (act)
                        gbte_pkg::ACT_INSERT: begin
                            n_ovalid  = 1'b1;
                            n_ostatus = full;
                            n_oamount = '0;
                            n_ochar   = '0;
                            n_ocv     = 1'b0;
                            n_olast   = 1'b1;
                            if (!full) begin
                                wr_en    = 1'b1;
                                wr_addr  = r_before[ADDR_W-1:0];
                                wr_data  = i_text_char;
                                n_before = r_before + LEN_W'(1);
                            end
                        end
                        gbte_pkg::ACT_DELETE: begin
                            n_before  = r_before - clip_before;
                            n_ovalid  = 1'b1;
                            n_ostatus = 1'b0;
                            n_oamount = AMT_W'(clip_before);
                            n_ochar   = '0;
                            n_ocv     = 1'b0;
                            n_olast   = 1'b1;
                        end
                        gbte_pkg::ACT_MOVE_LEFT: begin
                            n_rem       = clip_before;
                            n_dir_right = 1'b0;
                            n_state     = gbte_pkg::ST_COPY;
                        end
                        gbte_pkg::ACT_MOVE_RIGHT: begin
                            n_rem       = clip_after;
                            n_dir_right = 1'b1;
                            n_state     = gbte_pkg::ST_COPY;
                        end
                    endcase
                end
            end
            gbte_pkg::ST_COPY: begin
                // finish the write of the word read last cycle
                if (r_wv) begin
                    wr_en   = 1'b1;
                    wr_addr = r_waddr;
                    wr_data = r_rdata;
                end
                if (r_rem != '0) begin
                    rd_en = 1'b1;
                    n_wv  = 1'b1;
                    n_rem = r_rem - LEN_W'(1);
                    if (r_dir_right) begin
                        rd_addr  = ADDR_W'(CAP_LEN - r_after);
                        n_waddr  = r_before[ADDR_W-1:0];
                        n_after  = r_after - LEN_W'(1);
                        n_before = r_before + LEN_W'(1);
                    end else begin
                        rd_addr  = ADDR_W'(r_before - LEN_W'(1));
                        n_waddr  = ADDR_W'(CAP_LEN - r_after - LEN_W'(1));
                        n_before = r_before - LEN_W'(1);
                        n_after  = r_after + LEN_W'(1);
                    end
                end else if (!r_wv) begin
                    n_wlen  = WIN_W'(win_len);
                    n_wleft = WIN_W'(win_len);
                    n_wpos  = ADDR_W'(r_before - win_len);
                    n_state = gbte_pkg::ST_WIN_RD;
                end
            end
            gbte_pkg::ST_WIN_RD: begin
                if (r_wleft == '0) begin
                    if (out_free) begin
                        n_ovalid  = 1'b1;
                        n_ostatus = 1'b0;
                        n_oamount = '0;
                        n_ochar   = '0;
                        n_ocv     = 1'b0;
                        n_olast   = 1'b1;
                        n_state   = gbte_pkg::ST_IDLE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_wpos;
                    n_state = gbte_pkg::ST_WIN_CAP;
                end
            end
            gbte_pkg::ST_WIN_CAP: begin
                // hold the read word until the output register frees up
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = 1'b0;
                    n_oamount = AMT_W'(r_wlen);
                    n_ochar   = r_rdata;
                    n_ocv     = 1'b1;
                    n_olast   = (r_wleft == WIN_W'(1));
                    n_wpos    = r_wpos + ADDR_W'(1);
                    n_wleft   = r_wleft - WIN_W'(1);
                    n_state   = (r_wleft == WIN_W'(1)) ? gbte_pkg::ST_IDLE
                                                       : gbte_pkg::ST_WIN_RD;
                end
            end
            default: begin
                n_state = gbte_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gbte_pkg::ST_IDLE;
            r_before <= '0;
            r_after  <= '0;
            r_rem    <= '0;
            r_wv     <= 1'b0;
            r_wleft  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_before <= n_before;
            r_after  <= n_after;
            r_rem    <= n_rem;
            r_wv     <= n_wv;
            r_wleft  <= n_wleft;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dir_right <= n_dir_right;
        r_waddr     <= n_waddr;
        r_wpos      <= n_wpos;
        r_wlen      <= n_wlen;
        r_ostatus   <= n_ostatus;
        r_oamount   <= n_oamount;
        r_ochar     <= n_ochar;
        r_ocv       <= n_ocv;
        r_olast     <= n_olast;
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_amount      = r_oamount;
    assign o_window_char = r_ochar;
    assign o_char_valid  = r_ocv;
    assign o_last        = r_olast;

    // text never outgrows the store
    `GBTE_ASSERT(a_fill_bound, i_clk, i_rst_n, fill <= {1'b0, CAP_LEN})
    // no copy write may be left pending once back in idle
    `GBTE_ASSERT(a_idle_no_write, i_clk, i_rst_n, (r_state == gbte_pkg::ST_IDLE) |-> !r_wv)
    // a window word always has a nonzero window length
    `GBTE_ASSERT(a_char_amount, i_clk, i_rst_n, (r_ovalid && r_ocv) |-> (r_oamount != '0))
    // an accepted insert into a store with room grows the left side by one
    `GBTE_ASSERT(a_insert_grow, i_clk, i_rst_n,
        (in_acc && act == gbte_pkg::ACT_INSERT && !full) |=>
        (r_before == $past(r_before) + LEN_W'(1)))

endmodule

`default_nettype wire

@@ bench/gap_buffer_text_editor_top_tb.sv @@
// Self-checking testbench for the gap buffer text editor top level.
`timescale 1ns / 1ps

module gap_buffer_text_editor_top_tb;

    typedef struct packed {
        logic                        status;
        logic [gbte_pkg::AMT_W-1:0]  amount;
        logic [gbte_pkg::CHAR_W-1:0] wchar;
        logic                        char_ok;
        logic                        last_flag;
    } t_edit_word;

    localparam int REPORT_MAX = 10;

    // Tracks the text buffer contents and the words each action must produce.
    class edit_scoreboard;
        logic [gbte_pkg::CHAR_W-1:0] text_mem [gbte_pkg::CAPACITY];
        logic [gbte_pkg::LEN_W-1:0]  left_len;
        logic [gbte_pkg::LEN_W-1:0]  right_len;
        t_edit_word                  expected_words [$];
        int                          fail_count;

        function new();
            left_len   = '0;
            right_len  = '0;
            fail_count = 0;
        endfunction

        function void push_word(logic st, logic [gbte_pkg::AMT_W-1:0] amt,
                                logic [gbte_pkg::CHAR_W-1:0] c, logic ok, logic lst);
            t_edit_word w;
            w.status    = st;
            w.amount    = amt;
            w.wchar     = c;
            w.char_ok   = ok;
            w.last_flag = lst;
            expected_words.insert(expected_words.size(), w);
        endfunction

        // Queue up to WINDOW characters left of the cursor, oldest first, or one empty word.
        function void push_cursor_window();
            int span;
            int base;
            span = (left_len < gbte_pkg::WINDOW) ? int'(left_len) : gbte_pkg::WINDOW;
            base = int'(left_len) - span;
            if (span == 0) begin
                push_word(1'b0, '0, '0, 1'b0, 1'b1);
            end else begin
                for (int i = 0; i < span; i++)
                    push_word(1'b0, gbte_pkg::AMT_W'(span),
                              text_mem[gbte_pkg::ADDR_W'(base + i)], 1'b1, i == span - 1);
            end
        endfunction

        function void note_input(gbte_pkg::t_action act, logic [gbte_pkg::CHAR_W-1:0] ch,
                                 logic [gbte_pkg::COUNT_W-1:0] cnt);
            int n;
            case (act)
                gbte_pkg::ACT_INSERT: begin
                    if (int'(left_len) + int'(right_len) >= gbte_pkg::CAPACITY) begin
                        push_word(1'b1, '0, '0, 1'b0, 1'b1);
                    end else begin
                        text_mem[left_len[gbte_pkg::ADDR_W-1:0]] = ch;
                        left_len++;
                        push_word(1'b0, '0, '0, 1'b0, 1'b1);
                    end
                end
                gbte_pkg::ACT_DELETE: begin
                    n = (cnt < left_len) ? int'(cnt) : int'(left_len);
                    left_len -= gbte_pkg::LEN_W'(n);
                    push_word(1'b0, gbte_pkg::AMT_W'(n), '0, 1'b0, 1'b1);
                end
                gbte_pkg::ACT_MOVE_LEFT: begin
                    n = (cnt < left_len) ? int'(cnt) : int'(left_len);
                    repeat (n) begin
                        left_len--;
                        right_len++;
                        text_mem[gbte_pkg::ADDR_W'(gbte_pkg::CAPACITY - int'(right_len))] =
                            text_mem[left_len[gbte_pkg::ADDR_W-1:0]];
                    end
                    push_cursor_window();
                end
                default: begin
                    n = (cnt < right_len) ? int'(cnt) : int'(right_len);
                    repeat (n) begin
                        text_mem[left_len[gbte_pkg::ADDR_W-1:0]] =
                            text_mem[gbte_pkg::ADDR_W'(gbte_pkg::CAPACITY - int'(right_len))];
                        right_len--;
                        left_len++;
                    end
                    push_cursor_window();
                end
            endcase
        endfunction

        function string word_text(t_edit_word w);
            return $sformatf("st=%0b amt=%0d ch=%02h ok=%0b last=%0b",
                             w.status, w.amount, w.wchar, w.char_ok, w.last_flag);
        endfunction

        function void check_word(t_edit_word got);
            t_edit_word want;
            if (expected_words.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("%0t: unexpected word %s", $realtime, word_text(got));
                return;
            end
            want = expected_words.pop_front();
            if (got.status !== want.status || got.amount !== want.amount ||
                got.wchar !== want.wchar || got.char_ok !== want.char_ok ||
                got.last_flag !== want.last_flag) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("%0t: mismatch exp %s got %s", $realtime, word_text(want),
                             word_text(got));
            end
        endfunction
    endclass

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic [1:0]                     i_action    = '0;
    logic [gbte_pkg::CHAR_W-1:0]    i_text_char = '0;
    logic [gbte_pkg::COUNT_W-1:0]   i_count     = '0;
    logic                           i_out_stall = 1'b0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic                           o_status;
    logic [gbte_pkg::AMT_W-1:0]     o_amount;
    logic [gbte_pkg::CHAR_W-1:0]    o_window_char;
    logic                           o_char_valid;
    logic                           o_last;

    edit_scoreboard sb;
    int             burst_left = 0;
    bit             hold_req   = 1'b0;

    gap_buffer_text_editor_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_text_char   (i_text_char),
        .i_count       (i_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_amount      (o_amount),
        .o_window_char (o_window_char),
        .o_char_valid  (o_char_valid),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Offer one word in bursts with random gaps; return once it is taken.
    task automatic send_word(input gbte_pkg::t_action act,
                             input logic [gbte_pkg::CHAR_W-1:0] ch,
                             input logic [gbte_pkg::COUNT_W-1:0] cnt);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_text_char <= ch;
        i_count     <= cnt;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(act, ch, cnt);
    endtask

    // Sink side: stall at a rate that changes now and then, plus one long hold-off.
    initial begin : sink_side
        int  mode_left;
        int  stall_pct;
        bit  hold_done;
        mode_left = 0;
        stall_pct = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                case ($urandom_range(3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                mode_left = $urandom_range(20, 100);
            end
            mode_left--;
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_edit_word got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status    = o_status;
            got.amount    = o_amount;
            got.wchar     = o_window_char;
            got.char_ok   = o_char_valid;
            got.last_flag = o_last;
            sb.check_word(got);
        end
    end

    initial begin : watchdog
        #(5_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        gbte_pkg::t_action            act;
        logic [gbte_pkg::COUNT_W-1:0] cnt;
        int                           pick;
        int                           run_len;
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty buffer, byte extremes, clipping, window shorter than full.
        send_word(gbte_pkg::ACT_MOVE_LEFT, 8'h00, 16'h0000);
        send_word(gbte_pkg::ACT_MOVE_RIGHT, 8'h00, 16'hFFFF);
        send_word(gbte_pkg::ACT_DELETE, 8'h00, 16'hFFFF);
        send_word(gbte_pkg::ACT_INSERT, 8'h00, 16'h0000);
        send_word(gbte_pkg::ACT_INSERT, 8'hFF, 16'h0000);
        send_word(gbte_pkg::ACT_INSERT, 8'hA5, 16'h0000);
        send_word(gbte_pkg::ACT_INSERT, 8'h5A, 16'h0000);
        for (int i = 0; i < 8; i++)
            send_word(gbte_pkg::ACT_INSERT, gbte_pkg::CHAR_W'(8'h61 + i), 16'h0000);
        send_word(gbte_pkg::ACT_MOVE_LEFT, 8'h00, 16'd3);
        send_word(gbte_pkg::ACT_MOVE_RIGHT, 8'h00, 16'hFFFF);
        send_word(gbte_pkg::ACT_MOVE_LEFT, 8'h00, 16'hFFFF);
        send_word(gbte_pkg::ACT_MOVE_RIGHT, 8'h00, 16'd5);
        send_word(gbte_pkg::ACT_DELETE, 8'h00, 16'd2);
        send_word(gbte_pkg::ACT_DELETE, 8'h00, 16'd0);
        send_word(gbte_pkg::ACT_MOVE_RIGHT, 8'h00, 16'd0);
        send_word(gbte_pkg::ACT_DELETE, 8'h00, 16'hFFFF);
        send_word(gbte_pkg::ACT_MOVE_RIGHT, 8'h00, 16'hFFFF);
        send_word(gbte_pkg::ACT_INSERT, 8'h7E, 16'hFFFF);

        // Random editing: typed runs of text mixed with deletes and cursor moves.
        for (int i = 0; i < 85; i++) begin
            if (i == 30)
                hold_req = 1'b1;
            pick = $urandom_range(99);
            if (pick < 12) begin
                run_len = $urandom_range(3, 12);
                repeat (run_len)
                    send_word(gbte_pkg::ACT_INSERT,
                              gbte_pkg::CHAR_W'($urandom_range(32, 126)),
                              gbte_pkg::COUNT_W'($urandom));
                continue;
            end
            if (pick < 50)      act = gbte_pkg::ACT_INSERT;
            else if (pick < 62) act = gbte_pkg::ACT_DELETE;
            else if (pick < 81) act = gbte_pkg::ACT_MOVE_LEFT;
            else                act = gbte_pkg::ACT_MOVE_RIGHT;
            pick = $urandom_range(99);
            if (pick < 70)      cnt = gbte_pkg::COUNT_W'($urandom_range(15));
            else if (pick < 85) cnt = gbte_pkg::COUNT_W'($urandom_range(int'(sb.left_len) + 5));
            else                cnt = gbte_pkg::COUNT_W'($urandom);
            send_word(act, gbte_pkg::CHAR_W'($urandom_range(255)), cnt);
        end

        // Sweep the cursor across the text with inserts and a delete in between.
        send_word(gbte_pkg::ACT_MOVE_LEFT, 8'h00, 16'd1000);
        send_word(gbte_pkg::ACT_INSERT, 8'h33, 16'h0000);
        send_word(gbte_pkg::ACT_MOVE_LEFT, 8'h00, 16'hFFFF);
        send_word(gbte_pkg::ACT_INSERT, 8'hCC, 16'h0000);
        send_word(gbte_pkg::ACT_MOVE_RIGHT, 8'h00, 16'd2000);
        send_word(gbte_pkg::ACT_MOVE_RIGHT, 8'h00, 16'hFFFF);
        send_word(gbte_pkg::ACT_DELETE, 8'h00, 16'hFFFF);
        send_word(gbte_pkg::ACT_MOVE_LEFT, 8'h00, 16'hFFFF);
        send_word(gbte_pkg::ACT_INSERT, 8'h21, 16'h0000);
        send_word(gbte_pkg::ACT_MOVE_RIGHT, 8'h00, 16'd1);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (sb.fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
